/* hdl/tpfag_pkg.sv */
// shared types, constants and helpers of the tensor permute and flip address generator
package tpfag_pkg;

   localparam int DimWidth    = 12;
   localparam int DataWidth   = 32;
   localparam int OffWidth    = 48;
   localparam int NumDims     = 4;
   localparam int SelWidth    = 2;
   localparam int PermWidth   = SelWidth * NumDims;
   localparam int CsrIdxWidth = 3;
   localparam int ProdWidth   = OffWidth + DimWidth;

   typedef logic [CsrIdxWidth-1:0] csr_index_type;
   typedef logic [DimWidth-1:0]    dim_type;
   typedef logic [SelWidth-1:0]    sel_type;

   localparam csr_index_type CSR_DIM_LEN_0 = csr_index_type'(0);
   localparam csr_index_type CSR_DIM_LEN_1 = csr_index_type'(1);
   localparam csr_index_type CSR_DIM_LEN_2 = csr_index_type'(2);
   localparam csr_index_type CSR_DIM_LEN_3 = csr_index_type'(3);
   localparam csr_index_type CSR_PERM      = csr_index_type'(4);
   localparam csr_index_type CSR_FLIP_HW   = csr_index_type'(5);

   localparam dim_type              DIM_LEN_RESET = dim_type'(1);
   localparam logic [PermWidth-1:0] PERM_RESET    = PermWidth'(228);

   // first flipped dimension (height), width follows it
   localparam int FlipFirstDim = 2;

   typedef struct packed {
      logic    load;
      logic    mac;
      sel_type mac_dim;
      logic    out_load;
   } cmd_type;

   function automatic dim_type extent_of(input dim_type size);
      return (size == '0) ? dim_type'(1) : size;
   endfunction

endpackage

/* hdl/tpfag_ctrl.sv */
// controller: sequences load, three multiply-add passes and the output register
module tpfag_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpfag_pkg::cmd_type cmd
);
   import tpfag_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   localparam sel_type LastStep = sel_type'(NumDims - 2);

   state_type state_ff, state_in;
   sel_type   step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.mac     = 1'b1;
            cmd.mac_dim = step_ff + sel_type'(1);
            if (step_ff == LastStep) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + sel_type'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/tpfag_datapath.sv */
// datapath: configuration registers, coordinate counters, multiply-add unit, output register
module tpfag_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  tpfag_pkg::csr_index_type              csr_index,
   input  logic [tpfag_pkg::DimWidth-1:0]        csr_write_data,
   input  tpfag_pkg::cmd_type                    cmd,
   input  logic [tpfag_pkg::DataWidth-1:0]       req_data_value,
   output logic [tpfag_pkg::OffWidth-1:0]        rsp_dest_offset,
   output logic [tpfag_pkg::DataWidth-1:0]       rsp_data_out,
   output logic                                  rsp_last_element
);
   import tpfag_pkg::*;

   dim_type              dim_len_ff [NumDims];
   logic [PermWidth-1:0] perm_ff;
   logic                 flip_ff;
   dim_type              cnt_ff [NumDims];
   dim_type              cnt_in [NumDims];
   dim_type              src_ff [NumDims];
   dim_type              src    [NumDims];
   dim_type              ext    [NumDims];
   logic [NumDims-1:0]   at_end;
   logic [NumDims:0]     carry;
   logic                 last_ff;
   logic [DataWidth-1:0] data_ff;
   logic [OffWidth-1:0]  acc_ff, acc_in;
   logic [ProdWidth-1:0] prod;
   sel_type              first_sel, mac_sel;

   logic [OffWidth-1:0]  out_offset_ff;
   logic [DataWidth-1:0] out_data_ff;
   logic                 out_last_ff;

   // extents, end flags and optionally mirrored source coordinate
   always_comb begin
      for (int d = 0; d < NumDims; d++) begin
         ext[d]    = extent_of(dim_len_ff[d]);
         at_end[d] = (cnt_ff[d] >= ext[d] - dim_type'(1));
         if (flip_ff && (d >= FlipFirstDim)) begin
            src[d] = ext[d] - dim_type'(1) - cnt_ff[d];
         end else begin
            src[d] = cnt_ff[d];
         end
      end
   end

   // mixed-radix advance, fastest dimension last
   always_comb begin
      carry[NumDims] = 1'b1;
      for (int d = NumDims - 1; d >= 0; d--) begin
         if (carry[d+1] && at_end[d]) begin
            cnt_in[d] = '0;
            carry[d]  = 1'b1;
         end else if (carry[d+1]) begin
            cnt_in[d] = cnt_ff[d] + dim_type'(1);
            carry[d]  = 1'b0;
         end else begin
            cnt_in[d] = cnt_ff[d];
            carry[d]  = 1'b0;
         end
      end
   end

   assign first_sel = perm_ff[SelWidth-1:0];
   assign mac_sel   = perm_ff[{cmd.mac_dim, 1'b0} +: SelWidth];
   assign prod      = ProdWidth'(acc_ff) * ProdWidth'(ext[mac_sel]);
   assign acc_in    = prod[OffWidth-1:0] + OffWidth'(src_ff[mac_sel]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NumDims; d++) begin
            dim_len_ff[d] <= DIM_LEN_RESET;
            cnt_ff[d]     <= '0;
         end
         perm_ff <= PERM_RESET;
         flip_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIM_LEN_0: dim_len_ff[0] <= csr_write_data;
               CSR_DIM_LEN_1: dim_len_ff[1] <= csr_write_data;
               CSR_DIM_LEN_2: dim_len_ff[2] <= csr_write_data;
               CSR_DIM_LEN_3: dim_len_ff[3] <= csr_write_data;
               CSR_PERM:      perm_ff       <= csr_write_data[PermWidth-1:0];
               CSR_FLIP_HW:   flip_ff       <= csr_write_data[0];
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff  <= src;
         last_ff <= &at_end;
         data_ff <= req_data_value;
         acc_ff  <= OffWidth'(src[first_sel]);
      end else if (cmd.mac) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_load) begin
         out_offset_ff <= acc_ff;
         out_data_ff   <= data_ff;
         out_last_ff   <= last_ff;
      end
   end

   assign rsp_dest_offset  = out_offset_ff;
   assign rsp_data_out     = out_data_ff;
   assign rsp_last_element = out_last_ff;

endmodule

/* hdl/tensor_permute_flip_address_gen.sv */
// top level of the tensor permute and flip address generator
//
// elements of a 4-d tensor enter on the req_ channel in source row-major order,
// one transaction per element. each rsp_ transaction carries the element's
// row-major offset in the permuted (and optionally h/w mirrored) destination,
// the element bits unchanged and a flag on the tensor's last element.
// extents, order and flip are set through the csr_ write port; the user must
// write them only while idle, the block itself does not enforce it.
// a new element is accepted only after the last has moved to the output register.
// the single shared 48x12 multiply-add unit makes three passes per element.
// the output register holds a result while rsp_stall is high; the next
// element may be accepted and computed meanwhile, then waits for the register.
// reset: counters cleared, extents 1, identity order, flip off, nothing pending.
// the counters wrap after the last element, ready for the next tensor.
module tensor_permute_flip_address_gen (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  tpfag_pkg::csr_index_type          csr_index,
   input  logic [tpfag_pkg::DimWidth-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tpfag_pkg::DataWidth-1:0]   req_data_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tpfag_pkg::OffWidth-1:0]    rsp_dest_offset,
   output logic [tpfag_pkg::DataWidth-1:0]   rsp_data_out,
   output logic                              rsp_last_element
);
   import tpfag_pkg::*;

   cmd_type cmd;

   tpfag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tpfag_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .req_data_value   (req_data_value),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_element (rsp_last_element)
   );

endmodule

/* tb/tb.sv */
// self-checking testbench of the tensor permute and flip address generator
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpfag_pkg::*;

   typedef struct packed {
      logic [OffWidth-1:0]  dest_offset;
      logic [DataWidth-1:0] data_out;
      logic                 last_element;
   } element_result_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_write_enable = 1'b0;
   csr_index_type        csr_index        = CSR_DIM_LEN_0;
   logic [DimWidth-1:0]  csr_write_data   = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [DataWidth-1:0] req_data_value   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [OffWidth-1:0]  rsp_dest_offset;
   logic [DataWidth-1:0] rsp_data_out;
   logic                 rsp_last_element;

   dim_type              dim_len [NumDims];
   logic [PermWidth-1:0] perm_order;
   logic                 flip_hw;
   dim_type              coord [NumDims];

   element_result_type   pending_results [$];
   int                   error_count   = 0;
   int                   send_idle_pct = 18;
   int                   recv_idle_pct = 79;

   tensor_permute_flip_address_gen DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_element (rsp_last_element)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic dim_type extent_at(int d);
      return (dim_len[d] == '0) ? dim_type'(1) : dim_len[d];
   endfunction

   // offset in the permuted shape, then step the source coordinate
   function automatic element_result_type predict_element(logic [DataWidth-1:0] value);
      dim_type            src [NumDims];
      longint unsigned    off;
      logic               last;
      logic               carry;
      int                 sel;
      element_result_type res;
      off   = 0;
      last  = 1'b1;
      carry = 1'b1;
      for (int i = 0; i < NumDims; i++) begin
         src[i] = coord[i];
         if (flip_hw && i >= FlipFirstDim)
            src[i] = extent_at(i) - dim_type'(1) - coord[i];
         if (coord[i] < extent_at(i) - dim_type'(1))
            last = 1'b0;
      end
      for (int i = 0; i < NumDims; i++) begin
         sel = perm_order[SelWidth*i +: SelWidth];
         off = (off * extent_at(sel) + src[sel]) & 64'h0000_FFFF_FFFF_FFFF;
      end
      for (int d = NumDims - 1; d >= 0; d--) begin
         if (carry) begin
            if (coord[d] >= extent_at(d) - dim_type'(1)) begin
               coord[d] = '0;
            end else begin
               coord[d] = coord[d] + dim_type'(1);
               carry    = 1'b0;
            end
         end
      end
      res.dest_offset  = off[OffWidth-1:0];
      res.data_out     = value;
      res.last_element = last;
      return res;
   endfunction

   always @(posedge clock) begin
      element_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction offset %h data %h last %b",
                     $time, rsp_dest_offset, rsp_data_out, rsp_last_element);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_dest_offset !== want.dest_offset) begin
               $display("%0t: dest_offset expected %h actual %h",
                        $time, want.dest_offset, rsp_dest_offset);
               error_count++;
            end
            if (rsp_data_out !== want.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, want.data_out, rsp_data_out);
               error_count++;
            end
            if (rsp_last_element !== want.last_element) begin
               $display("%0t: last_element expected %b actual %b",
                        $time, want.last_element, rsp_last_element);
               error_count++;
            end
         end
      end
   end

   task automatic write_register(csr_index_type idx, logic [DimWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic configure(dim_type s0, dim_type s1, dim_type s2, dim_type s3,
                            logic [PermWidth-1:0] perm, logic flip);
      write_register(CSR_DIM_LEN_0, s0);
      write_register(CSR_DIM_LEN_1, s1);
      write_register(CSR_DIM_LEN_2, s2);
      write_register(CSR_DIM_LEN_3, s3);
      write_register(CSR_PERM, DimWidth'(perm));
      write_register(CSR_FLIP_HW, DimWidth'(flip));
      csr_write_enable <= 1'b0;
      dim_len[0] = s0;
      dim_len[1] = s1;
      dim_len[2] = s2;
      dim_len[3] = s3;
      perm_order = perm;
      flip_hw    = flip;
   endtask

   task automatic send_element(logic [DataWidth-1:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_data_value <= value;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), predict_element(value));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_reset_state();
      send_element('0);
      send_element('1);
   endtask

   task automatic test_flip_reverse_order();
      wait_idle();
      configure(12'd1, 12'd2, 12'd2, 12'd3, 8'b00_01_10_11, 1'b1);
      repeat (12) send_element($urandom());
   endtask

   task automatic test_zero_extent_repeated_selectors();
      wait_idle();
      configure(12'd0, 12'd3, 12'd0, 12'd2, 8'b01_01_11_11, 1'b0);
      repeat (6) send_element($urandom());
   endtask

   // counters left beyond the new extents, mirror wraps round
   task automatic test_extent_limits_midtensor_change();
      wait_idle();
      configure(12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'h00, 1'b1);
      repeat (2) send_element($urandom());
      wait_idle();
      configure(12'd1, 12'd1, 12'd1, 12'd1, 8'hFF, 1'b1);
      repeat (2) send_element($urandom());
   endtask

   task automatic test_random_tensors(int item_target);
      int                   sent;
      int                   burst;
      int                   j;
      int                   tmp;
      int                   order [NumDims];
      dim_type              sizes [NumDims];
      logic [PermWidth-1:0] perm;
      longint               volume;
      longint               pos;
      logic                 beyond;
      sent = 0;
      while (sent < item_target) begin
         for (int d = 0; d < NumDims; d++) begin
            case ($urandom_range(0, 19))
               0:       sizes[d] = '0;
               1:       sizes[d] = dim_type'($urandom_range(1, 4095));
               2:       sizes[d] = dim_type'(4095);
               default: sizes[d] = dim_type'($urandom_range(1, 4));
            endcase
         end
         if ($urandom_range(0, 4) != 0) begin
            for (int k = 0; k < NumDims; k++) order[k] = k;
            for (int k = NumDims - 1; k > 0; k--) begin
               j        = $urandom_range(0, k);
               tmp      = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            for (int k = 0; k < NumDims; k++) perm[SelWidth*k +: SelWidth] = sel_type'(order[k]);
         end else begin
            perm = PermWidth'($urandom_range(0, 255));
         end
         wait_idle();
         configure(sizes[0], sizes[1], sizes[2], sizes[3], perm, 1'($urandom_range(0, 1)));
         volume = 1;
         pos    = 0;
         beyond = 1'b0;
         for (int d = 0; d < NumDims; d++) begin
            if (coord[d] >= extent_at(d)) beyond = 1'b1;
            volume = volume * extent_at(d);
            pos    = pos * extent_at(d) + coord[d];
         end
         // mostly finish the current tensor and maybe one more, else a broken run
         if (!beyond && volume <= 96 && $urandom_range(0, 5) != 0)
            burst = int'(volume - pos + volume * $urandom_range(0, 1));
         else
            burst = $urandom_range(1, 24);
         repeat (burst) send_element($urandom());
         sent += burst;
      end
      wait_idle();
   endtask

   initial begin
      for (int d = 0; d < NumDims; d++) begin
         dim_len[d] = DIM_LEN_RESET;
         coord[d]   = '0;
      end
      perm_order = PERM_RESET;
      flip_hw    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_flip_reverse_order();
      test_zero_extent_repeated_selectors();
      test_extent_limits_midtensor_change();
      test_random_tensors(560);
      send_idle_pct = 79;
      recv_idle_pct = 18;
      test_random_tensors(560);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_tensors(560);
      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
